/* rtl/core/dirty_region_refresh_tracker_assert.svh */
// Assertion helpers for the refresh tracker; clk and rst are taken from the using scope.
`ifndef DIRTY_REGION_REFRESH_TRACKER_ASSERT_SVH
`define DIRTY_REGION_REFRESH_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define DRRT_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define DRRT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* rtl/core/drrt_pkg.sv */
`default_nettype none
package drrt_pkg;

  localparam logic [1:0] MODE_INVALIDATE = 2'd0;
  localparam logic [1:0] MODE_UPDATE     = 2'd1;
  localparam logic [1:0] MODE_RESET      = 2'd2;

  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_BW   = 2'd1;
  localparam logic [1:0] KIND_GS   = 2'd2;

  localparam int REG_BITS       = 12;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [REG_BITS-1:0] RESET_WIDTH  = 12'd600;
  localparam logic [REG_BITS-1:0] RESET_HEIGHT = 12'd800;

  // area > floor(W*H*95/100) is the same test as area*100 > W*H*95
  localparam int THRESH_NUM = 95;
  localparam int THRESH_DEN = 100;
  localparam int LIMIT_BITS = 2 * REG_BITS + 7;

  typedef struct packed {
    logic valid;
    logic bw_valid;
    logic gs_valid;
  } stage_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/drrt_limit.sv */
`default_nettype none
module drrt_limit
  import drrt_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data,
  output logic      [LIMIT_BITS-1:0]     limit
);

  localparam int PROD_BITS = 2 * REG_BITS;
  localparam logic [PROD_BITS-1:0] RESET_PROD =
    PROD_BITS'(RESET_WIDTH) * PROD_BITS'(RESET_HEIGHT);
  localparam logic [LIMIT_BITS-1:0] RESET_LIMIT =
    LIMIT_BITS'(RESET_PROD) * LIMIT_BITS'(THRESH_NUM);

  logic [REG_BITS-1:0]  screen_width;
  logic [REG_BITS-1:0]  screen_height;
  logic [PROD_BITS-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  screen_width  <= cfg_data;
        CFG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // two registered steps: the product, then the scaled limit
  always_ff @(posedge clk) begin
    if (rst) begin
      prod  <= RESET_PROD;
      limit <= RESET_LIMIT;
    end else begin
      prod  <= PROD_BITS'(screen_width) * PROD_BITS'(screen_height);
      limit <= LIMIT_BITS'(prod) * LIMIT_BITS'(THRESH_NUM);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/drrt_boxes.sv */
`default_nettype none
module drrt_boxes
  import drrt_pkg::*;
#(
  parameter int CB = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      mode,
  input  wire logic [CB-1:0]   rect_x,
  input  wire logic [CB-1:0]   rect_y,
  input  wire logic [CB-1:0]   rect_w,
  input  wire logic [CB-1:0]   rect_h,
  input  wire logic            is_black_white,
  input  wire logic            s2_free,
  output stage_ctl_t           s1_ctl,
  output logic [4*(CB+1)-1:0]  s1_bw_box,
  output logic [4*(CB+1)-1:0]  s1_gs_box,
  output logic [CB:0]          s1_uw,
  output logic [CB:0]          s1_uh
);

  localparam int E = CB + 1;

  logic         bw_valid, gs_valid;
  logic [E-1:0] bw_l, bw_t, bw_r, bw_b;
  logic [E-1:0] gs_l, gs_t, gs_r, gs_b;

  logic         accept;
  logic [E-1:0] x_e, y_e, r_e, b_e;
  logic         cur_valid;
  logic [E-1:0] cur_l, cur_t, cur_r, cur_b;
  logic [E-1:0] g_l, g_t, g_r, g_b;
  logic [E-1:0] u_l, u_t, u_r, u_b;

  logic         s1_valid, s1_bwv, s1_gsv;

  assign in_stall = s1_valid && !s2_free;
  assign accept   = in_valid && !in_stall;

  assign x_e = {1'b0, rect_x};
  assign y_e = {1'b0, rect_y};
  assign r_e = {1'b0, rect_x} + {1'b0, rect_w};
  assign b_e = {1'b0, rect_y} + {1'b0, rect_h};

  always_comb begin
    cur_valid = is_black_white ? bw_valid : gs_valid;
    cur_l     = is_black_white ? bw_l : gs_l;
    cur_t     = is_black_white ? bw_t : gs_t;
    cur_r     = is_black_white ? bw_r : gs_r;
    cur_b     = is_black_white ? bw_b : gs_b;
    // open on the rectangle when empty, otherwise grow
    g_l = (cur_valid && cur_l < x_e) ? cur_l : x_e;
    g_t = (cur_valid && cur_t < y_e) ? cur_t : y_e;
    g_r = (cur_valid && cur_r > r_e) ? cur_r : r_e;
    g_b = (cur_valid && cur_b > b_e) ? cur_b : b_e;
  end

  always_comb begin
    if (bw_valid && gs_valid) begin
      u_l = (bw_l < gs_l) ? bw_l : gs_l;
      u_t = (bw_t < gs_t) ? bw_t : gs_t;
      u_r = (bw_r > gs_r) ? bw_r : gs_r;
      u_b = (bw_b > gs_b) ? bw_b : gs_b;
    end else if (bw_valid) begin
      u_l = bw_l;
      u_t = bw_t;
      u_r = bw_r;
      u_b = bw_b;
    end else begin
      u_l = gs_l;
      u_t = gs_t;
      u_r = gs_r;
      u_b = gs_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bw_valid <= 1'b0;
      gs_valid <= 1'b0;
    end else if (accept) begin
      case (mode)
        MODE_INVALIDATE: begin
          if (is_black_white) bw_valid <= 1'b1;
          else gs_valid <= 1'b1;
        end
        MODE_UPDATE, MODE_RESET: begin
          bw_valid <= 1'b0;
          gs_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_INVALIDATE) begin
      if (is_black_white) begin
        bw_l <= g_l;
        bw_t <= g_t;
        bw_r <= g_r;
        bw_b <= g_b;
      end else begin
        gs_l <= g_l;
        gs_t <= g_t;
        gs_r <= g_r;
        gs_b <= g_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s2_free) begin
      s1_valid <= accept && mode == MODE_UPDATE;
    end
  end

  // snapshot the boxes as the update clears them
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_UPDATE) begin
      s1_bwv    <= bw_valid;
      s1_gsv    <= gs_valid;
      s1_bw_box <= {bw_l, bw_t, bw_r, bw_b};
      s1_gs_box <= {gs_l, gs_t, gs_r, gs_b};
      s1_uw     <= u_r - u_l;
      s1_uh     <= u_b - u_t;
    end
  end

  assign s1_ctl = '{valid: s1_valid, bw_valid: s1_bwv, gs_valid: s1_gsv};

endmodule
`default_nettype wire

/* rtl/core/drrt_area.sv */
`default_nettype none
module drrt_area
  import drrt_pkg::*;
#(
  parameter int CB = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire stage_ctl_t            s1_ctl,
  input  wire logic [4*(CB+1)-1:0]   s1_bw_box,
  input  wire logic [4*(CB+1)-1:0]   s1_gs_box,
  input  wire logic [CB:0]           s1_uw,
  input  wire logic [CB:0]           s1_uh,
  input  wire logic [LIMIT_BITS-1:0] limit,
  input  wire logic                  s3_free,
  output logic                       s2_free,
  output logic                       load,
  output logic [1:0]                 n,
  output logic [4*(CB+1)+2:0]        rec0,
  output logic [4*(CB+1)+2:0]        rec1
);

  localparam int E     = CB + 1;
  localparam int AREAW = 2 * E;
  localparam int CMPW  = (AREAW + 7 > LIMIT_BITS) ? AREAW + 7 : LIMIT_BITS;

  logic               s2_valid, s2_bwv, s2_gsv;
  logic [4*E-1:0]     s2_bw_box, s2_gs_box;
  logic [AREAW-1:0]   area;

  logic [CMPW-1:0]    scaled;
  logic               full;
  logic [E-1:0]       bl, bt, br, bb, gl, gt, gr, gb;
  logic [4*E+2:0]     rec_bw, rec_gs, rec_full;

  assign s2_free = !s2_valid || s3_free;
  assign load    = s2_valid && s3_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid && s2_free) begin
      s2_bwv    <= s1_ctl.bw_valid;
      s2_gsv    <= s1_ctl.gs_valid;
      s2_bw_box <= s1_bw_box;
      s2_gs_box <= s1_gs_box;
      area      <= AREAW'(s1_uw) * AREAW'(s1_uh);
    end
  end

  assign {bl, bt, br, bb} = s2_bw_box;
  assign {gl, gt, gr, gb} = s2_gs_box;

  always_comb begin
    scaled   = CMPW'(area) * CMPW'(THRESH_DEN);
    // with no open box the area counts as zero, whatever stale edges remain
    full     = (s2_bwv || s2_gsv) && (area != '0) && (scaled > CMPW'(limit));
    rec_full = {KIND_FULL, {(4*E){1'b0}}, 1'b1};
    rec_bw   = {KIND_BW, bl, bt, br - bl, bb - bt, !s2_gsv};
    rec_gs   = {KIND_GS, gl, gt, gr - gl, gb - gt, 1'b1};
    rec1     = rec_gs;
    if (full) begin
      n    = 2'd1;
      rec0 = rec_full;
    end else if (s2_bwv) begin
      n    = s2_gsv ? 2'd2 : 2'd1;
      rec0 = rec_bw;
    end else begin
      n    = s2_gsv ? 2'd1 : 2'd0;
      rec0 = rec_gs;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/drrt_emit.sv */
`default_nettype none
module drrt_emit
  import drrt_pkg::*;
#(
  parameter int CB = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic [1:0]         n,
  input  wire logic [4*(CB+1)+2:0] rec0,
  input  wire logic [4*(CB+1)+2:0] rec1,
  output logic                    s3_free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              refresh_kind,
  output logic [CB:0]             out_x,
  output logic [CB:0]             out_y,
  output logic [CB:0]             out_w,
  output logic [CB:0]             out_h,
  output logic                    last
);

  localparam int RECW = 4 * (CB + 1) + 3;

  logic [1:0]      cnt;
  logic [RECW-1:0] q0, q1, o_rec;
  logic            out_ok, pop;

  assign out_ok  = !out_valid || !out_stall;
  assign pop     = (cnt != 2'd0) && out_ok;
  assign s3_free = (cnt == 2'd0) || (cnt == 2'd1 && out_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) cnt <= n;
      else if (pop) cnt <= cnt - 2'd1;
      if (out_ok) out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0 <= rec0;
      q1 <= rec1;
    end else if (pop) begin
      q0 <= q1;
    end
    if (pop) o_rec <= q0;
  end

  assign {refresh_kind, out_x, out_y, out_w, out_h, last} = o_rec;

endmodule
`default_nettype wire

/* rtl/core/dirty_region_refresh_tracker.sv */
// Dirty bounding-box tracker with full/partial refresh selection.
// An update's first command passes the snapshot stage, the area multiply, the threshold compare
// into the command queue and the output register; its second follows it out of the queue.
// Throughput: one item per cycle while in_stall is low; the single output register gives one
// command a cycle while out_stall is low, so back-to-back two-command updates stall the input.
// Reset (synchronous, rst high): both boxes empty, pipeline empty, width 600, height 800.
`default_nettype none
`include "dirty_region_refresh_tracker_assert.svh"
module dirty_region_refresh_tracker
  import drrt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                mode,
  input  wire logic [COORD_BITS-1:0]     rect_x,
  input  wire logic [COORD_BITS-1:0]     rect_y,
  input  wire logic [COORD_BITS-1:0]     rect_w,
  input  wire logic [COORD_BITS-1:0]     rect_h,
  input  wire logic                      is_black_white,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     refresh_kind,
  output logic [COORD_BITS:0]            out_x,
  output logic [COORD_BITS:0]            out_y,
  output logic [COORD_BITS:0]            out_w,
  output logic [COORD_BITS:0]            out_h,
  output logic                           last
);

  localparam int E = COORD_BITS + 1;

  stage_ctl_t          s1_ctl;
  logic [4*E-1:0]      s1_bw_box, s1_gs_box;
  logic [E-1:0]        s1_uw, s1_uh;
  logic [LIMIT_BITS-1:0] limit;
  logic                s2_free, s3_free, load;
  logic [1:0]          n;
  logic [4*E+2:0]      rec0, rec1;
  logic                not_last, is_full, full_zero;

  drrt_limit u_limit (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limit     (limit)
  );

  drrt_boxes #(.CB(COORD_BITS)) u_boxes (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .rect_x         (rect_x),
    .rect_y         (rect_y),
    .rect_w         (rect_w),
    .rect_h         (rect_h),
    .is_black_white (is_black_white),
    .s2_free        (s2_free),
    .s1_ctl         (s1_ctl),
    .s1_bw_box      (s1_bw_box),
    .s1_gs_box      (s1_gs_box),
    .s1_uw          (s1_uw),
    .s1_uh          (s1_uh)
  );

  drrt_area #(.CB(COORD_BITS)) u_area (
    .clk       (clk),
    .rst       (rst),
    .s1_ctl    (s1_ctl),
    .s1_bw_box (s1_bw_box),
    .s1_gs_box (s1_gs_box),
    .s1_uw     (s1_uw),
    .s1_uh     (s1_uh),
    .limit     (limit),
    .s3_free   (s3_free),
    .s2_free   (s2_free),
    .load      (load),
    .n         (n),
    .rec0      (rec0),
    .rec1      (rec1)
  );

  drrt_emit #(.CB(COORD_BITS)) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .n            (n),
    .rec0         (rec0),
    .rec1         (rec1),
    .s3_free      (s3_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .refresh_kind (refresh_kind),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_w        (out_w),
    .out_h        (out_h),
    .last         (last)
  );

  assign not_last  = out_valid && !last;
  assign is_full   = out_valid && refresh_kind == KIND_FULL;
  assign full_zero = last && out_w == '0 && out_h == '0;

  `DRRT_ASSERT_IMPL(a_stall_needs_s1, in_stall, s1_ctl.valid, "stall with snapshot stage empty")
  `DRRT_ASSERT_NEXT(a_s1_holds, s1_ctl.valid && in_stall, s1_ctl.valid, "blocked snapshot lost")
  `DRRT_ASSERT_IMPL(a_nonlast_bw, not_last, refresh_kind == KIND_BW, "pair out of order")
  `DRRT_ASSERT_IMPL(a_full_shape, is_full, full_zero, "malformed full refresh")

endmodule
`default_nettype wire
